@@ rtl/accs_pkg.sv @@
// shared constants and calibration tables for the conductance smoother
package accs_pkg;

    localparam int CODE_W      = 10;
    localparam int ADC_BITS    = 10;
    localparam int NUM_POINTS  = 8;
    localparam int NUM_SEG     = NUM_POINTS - 1;
    localparam int COND_W      = 15;
    localparam int WEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int KNOT_W      = ADC_BITS;
    localparam int CMP_W       = (KNOT_W > CODE_W) ? KNOT_W : CODE_W;
    localparam int SLOPE_W     = 24;
    localparam int PROD_W      = SLOPE_W + WEIGHT_W;
    localparam int PT_W        = $clog2(NUM_POINTS);
    localparam int SEG_W       = (NUM_SEG > 1) ? $clog2(NUM_SEG) : 1;
    localparam int FRAC_W      = 16;
    localparam int STEP_SHIFT  = 8;

    localparam int unsigned FULL_SCALE_MV = 3300;
    localparam int unsigned FULL_CODE     = (2 ** ADC_BITS) - 1;
    localparam int unsigned KNOT_DIV      = 2 * FULL_SCALE_MV;

    localparam logic [CODE_W-1:0] CODE_MASK =
        (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'(FULL_CODE);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMOOTHING_WEIGHT = 2'd0,
        REG_VALID_MIN_CODE   = 2'd1,
        REG_VALID_MAX_CODE   = 2'd2
    } cfg_reg_t;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd6554;
    localparam logic [CODE_W-1:0]   VALID_MIN_RST = 10'd16;
    localparam logic [CODE_W-1:0]   VALID_MAX_RST = 10'd325;

    typedef logic [KNOT_W-1:0]  knot_t;
    typedef logic [COND_W-1:0]  cond_t;
    typedef logic [SLOPE_W-1:0] slope_t;

    localparam int unsigned KNOT_MV [NUM_POINTS] =
        '{100, 300, 500, 700, 850, 920, 970, 1000};

    localparam cond_t KNOT_COND [NUM_POINTS] =
        '{15'd20480, 15'd10240, 15'd5120, 15'd2048, 15'd1024, 15'd512, 15'd205, 15'd102};

    // millivolts to converter code, rounded half up
    function automatic int unsigned knot_code(int unsigned idx);
        return (KNOT_MV[idx] * FULL_CODE * 2 + FULL_SCALE_MV) / KNOT_DIV;
    endfunction

    function automatic int unsigned seg_len(int unsigned idx);
        return knot_code(idx + 1) - knot_code(idx);
    endfunction

    function automatic int unsigned seg_den(int unsigned idx);
        return (seg_len(idx) == 0) ? 1 : seg_len(idx);
    endfunction

    function automatic int unsigned seg_span(int unsigned idx);
        int unsigned a;
        int unsigned b;
        a = int'(KNOT_COND[idx]);
        b = int'(KNOT_COND[idx + 1]);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic cond_t cond_max();
        cond_t m;
        m = KNOT_COND[0];
        for (int i = 1; i < NUM_POINTS; i++) begin
            if (KNOT_COND[i] > m) begin
                m = KNOT_COND[i];
            end
        end
        return m;
    endfunction

    localparam knot_t KNOT_CODE [NUM_POINTS] = '{
        KNOT_W'(knot_code(0)), KNOT_W'(knot_code(1)), KNOT_W'(knot_code(2)),
        KNOT_W'(knot_code(3)), KNOT_W'(knot_code(4)), KNOT_W'(knot_code(5)),
        KNOT_W'(knot_code(6)), KNOT_W'(knot_code(7))
    };

    // segment slope magnitude, Q.8, rounded
    localparam slope_t SEG_SLOPE [NUM_SEG] = '{
        SLOPE_W'((seg_span(0) * 256 + seg_len(0) / 2) / seg_den(0)),
        SLOPE_W'((seg_span(1) * 256 + seg_len(1) / 2) / seg_den(1)),
        SLOPE_W'((seg_span(2) * 256 + seg_len(2) / 2) / seg_den(2)),
        SLOPE_W'((seg_span(3) * 256 + seg_len(3) / 2) / seg_den(3)),
        SLOPE_W'((seg_span(4) * 256 + seg_len(4) / 2) / seg_den(4)),
        SLOPE_W'((seg_span(5) * 256 + seg_len(5) / 2) / seg_den(5)),
        SLOPE_W'((seg_span(6) * 256 + seg_len(6) / 2) / seg_den(6))
    };

    localparam cond_t COND_MAX = cond_max();

endpackage

@@ rtl/adc_calibrated_conductance_smoother_unit.sv @@
// top level: adc window check, calibration interpolation and moving average
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  input    | s_valid / s_ready   | s_adc_code
//  result   | m_valid / m_ready   | m_sensor_present, m_raw_conductance,
//           |                     | m_smoothed_conductance
//  config   | cfg_wr_en           | cfg_index, cfg_data
//
// a present sample goes through lookup, segment multiply, raw, difference, average
// multiply and update, an absent one from lookup to output; one 24x16 multiplier
// serves segment product and average update. one transaction is in work at a time.
// synchronous active-low reset clears the sequencer, the average and the result valid.
// a stalled result holds in the output register while the next sample is accepted.
module adc_calibrated_conductance_smoother_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [accs_pkg::CODE_W-1:0]     s_adc_code,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_sensor_present,
    output logic [accs_pkg::COND_W-1:0]     m_raw_conductance,
    output logic [accs_pkg::COND_W-1:0]     m_smoothed_conductance,
    input  logic                            cfg_wr_en,
    input  logic [accs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [accs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import accs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_MUL_SEG,
        S_RAW,
        S_DIFF,
        S_MUL_EMA,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [CODE_W-1:0]      code_reg;
    logic                   present_reg;
    cond_t                  c1_reg;
    cond_t                  span_reg;
    logic                   rising_reg;
    slope_t                 slope_reg;
    logic [CMP_W-1:0]       d_reg;
    logic [PROD_W-1:0]      prod_reg;
    cond_t                  raw_reg;
    logic                   neg_reg;
    cond_t                  mag_reg;
    cond_t                  avg_reg;
    logic [WEIGHT_W-1:0]    weight_reg;
    logic [CODE_W-1:0]      vmin_reg;
    logic [CODE_W-1:0]      vmax_reg;
    logic                   m_valid_reg;
    logic                   m_present_reg;
    cond_t                  m_raw_reg;
    cond_t                  m_smooth_reg;

    // segment lookup
    logic [CMP_W-1:0]       code_ext;
    logic                   present;
    logic                   seg_hit;
    logic [SEG_W-1:0]       seg_idx;
    logic [PT_W-1:0]        seg_lo;
    logic [PT_W-1:0]        seg_hi;
    cond_t                  c1_next;
    cond_t                  span_next;
    logic                   rising_next;
    slope_t                 slope_next;
    logic [CMP_W-1:0]       d_next;

    always_comb begin
        code_ext = CMP_W'(code_reg);
        present  = (code_reg > vmin_reg) && (code_reg < vmax_reg);
        seg_hit  = 1'b0;
        seg_idx  = '0;
        for (int i = NUM_SEG - 1; i >= 0; i--) begin
            if ((KNOT_CODE[i+1] > KNOT_CODE[i]) && (code_ext >= CMP_W'(KNOT_CODE[i]))
                    && (code_ext < CMP_W'(KNOT_CODE[i+1]))) begin
                seg_hit = 1'b1;
                seg_idx = SEG_W'(i);
            end
        end
        seg_lo = PT_W'(seg_idx);
        seg_hi = PT_W'(seg_idx) + PT_W'(1);
        if (code_ext <= CMP_W'(KNOT_CODE[0])) begin
            c1_next     = KNOT_COND[0];
            span_next   = '0;
            rising_next = 1'b0;
            slope_next  = '0;
            d_next      = '0;
        end else if ((code_ext >= CMP_W'(KNOT_CODE[NUM_POINTS-1])) || !seg_hit) begin
            c1_next     = KNOT_COND[NUM_POINTS-1];
            span_next   = '0;
            rising_next = 1'b0;
            slope_next  = '0;
            d_next      = '0;
        end else begin
            c1_next     = KNOT_COND[seg_lo];
            rising_next = KNOT_COND[seg_hi] > KNOT_COND[seg_lo];
            span_next   = rising_next ? (KNOT_COND[seg_hi] - KNOT_COND[seg_lo])
                                      : (KNOT_COND[seg_lo] - KNOT_COND[seg_hi]);
            slope_next  = SEG_SLOPE[seg_idx];
            d_next      = code_ext - CMP_W'(KNOT_CODE[seg_lo]);
        end
    end

    // shared multiplier
    logic [SLOPE_W-1:0]     mul_a;
    logic [WEIGHT_W-1:0]    mul_b;
    logic [PROD_W-1:0]      mul_p;

    always_comb begin
        if (state_reg == S_MUL_SEG) begin
            mul_a = slope_reg;
            mul_b = WEIGHT_W'(d_reg);
        end else begin
            mul_a = SLOPE_W'(mag_reg);
            mul_b = weight_reg;
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // rounding, clamp to segment, average update
    logic [PROD_W-1:0]      step_full;
    cond_t                  step_c;
    cond_t                  raw_next;
    logic [COND_W:0]        diff;
    logic [PROD_W-1:0]      ema_sum;
    cond_t                  delta;
    cond_t                  avg_next;

    always_comb begin
        step_full = (prod_reg + PROD_W'(128)) >> STEP_SHIFT;
        step_c    = (step_full > PROD_W'(span_reg)) ? span_reg : step_full[COND_W-1:0];
        raw_next  = rising_reg ? (c1_reg + step_c) : (c1_reg - step_c);
        diff      = {1'b0, raw_reg} - {1'b0, avg_reg};
        ema_sum   = neg_reg ? (prod_reg + PROD_W'((2 ** FRAC_W) - 1)) : prod_reg;
        delta     = ema_sum[FRAC_W +: COND_W];
        avg_next  = neg_reg ? (avg_reg - delta) : (avg_reg + delta);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            avg_reg     <= '0;
            weight_reg  <= WEIGHT_RESET;
            vmin_reg    <= VALID_MIN_RST;
            vmax_reg    <= VALID_MAX_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SMOOTHING_WEIGHT: weight_reg <= cfg_data;
                    REG_VALID_MIN_CODE:   vmin_reg   <= cfg_data[CODE_W-1:0];
                    REG_VALID_MAX_CODE:   vmax_reg   <= cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        code_reg  <= s_adc_code & CODE_MASK;
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    present_reg <= present;
                    c1_reg      <= c1_next;
                    span_reg    <= span_next;
                    rising_reg  <= rising_next;
                    slope_reg   <= slope_next;
                    d_reg       <= d_next;
                    raw_reg     <= '0;
                    state_reg   <= present ? S_MUL_SEG : S_OUT;
                end
                S_MUL_SEG: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RAW;
                end
                S_RAW: begin
                    raw_reg   <= raw_next;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    neg_reg   <= diff[COND_W];
                    mag_reg   <= diff[COND_W] ? COND_W'(-diff) : diff[COND_W-1:0];
                    state_reg <= S_MUL_EMA;
                end
                S_MUL_EMA: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    avg_reg   <= avg_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_present_reg <= present_reg;
                        m_raw_reg     <= raw_reg;
                        m_smooth_reg  <= avg_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready                = (state_reg == S_IDLE);
    assign m_valid                = m_valid_reg;
    assign m_sensor_present       = m_present_reg;
    assign m_raw_conductance      = m_raw_reg;
    assign m_smoothed_conductance = m_smooth_reg;

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output step");

    a_absent_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_present_reg) |-> (m_raw_reg == '0))
        else $error("absent sample with nonzero raw conductance");

    a_raw_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_raw_reg <= COND_MAX) && (m_smooth_reg <= COND_MAX)))
        else $error("conductance beyond calibration range");

    a_avg_moves_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(avg_reg) |-> $past(state_reg == S_UPDATE))
        else $error("average changed outside update step");

endmodule

@@ bench/testbench.sv @@
// testbench for the calibrated conductance smoother: directed and random samples checked
`timescale 1ns / 1ps

module testbench;
    import accs_pkg::*;

    localparam int unsigned ADC_FULL   = (1 << ADC_BITS) - 1;
    localparam int unsigned CODE_TOP   = (1 << CODE_W) - 1;
    localparam int          STALL_LIMIT = 3000;
    localparam int          SETTLE_CYCLES = 12;

    typedef struct packed {
        logic              present;
        logic [COND_W-1:0] raw;
        logic [COND_W-1:0] smoothed;
    } reading_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [CODE_W-1:0]      s_adc_code;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_sensor_present;
    logic [COND_W-1:0]      m_raw_conductance;
    logic [COND_W-1:0]      m_smoothed_conductance;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [WEIGHT_W-1:0]    weight_shadow;
    logic [CODE_W-1:0]      min_shadow;
    logic [CODE_W-1:0]      max_shadow;
    logic [COND_W-1:0]      average_shadow;

    reading_t               expected_readings[$];
    reading_t               oldest_reading;
    int                     mismatch_count;
    int                     idle_pct;
    int                     stall_pct;
    int                     ready_hold;
    int                     quiet_cycles;

    adc_calibrated_conductance_smoother_unit dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_adc_code             (s_adc_code),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_sensor_present       (m_sensor_present),
        .m_raw_conductance      (m_raw_conductance),
        .m_smoothed_conductance (m_smoothed_conductance),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned cal_knot(input int unsigned idx);
        longint unsigned num;
        num = longint'(KNOT_MV[idx]) * ADC_FULL * 2 + FULL_SCALE_MV;
        return int'(num / (2 * FULL_SCALE_MV));
    endfunction

    function automatic logic [COND_W-1:0] cal_lookup(input logic [CODE_W-1:0] code);
        longint unsigned c;
        longint unsigned k1;
        longint unsigned k2;
        longint unsigned len;
        longint unsigned c1;
        longint unsigned c2;
        longint unsigned span;
        longint unsigned slope;
        longint unsigned step;
        c = code & CODE_MASK & ADC_FULL;
        if (c <= cal_knot(0)) begin
            return KNOT_COND[0];
        end
        if (c >= cal_knot(NUM_POINTS - 1)) begin
            return KNOT_COND[NUM_POINTS - 1];
        end
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
            k1 = cal_knot(i);
            k2 = cal_knot(i + 1);
            if (k2 > k1 && c >= k1 && c < k2) begin
                len  = k2 - k1;
                c1   = KNOT_COND[i];
                c2   = KNOT_COND[i + 1];
                span = (c1 >= c2) ? (c1 - c2) : (c2 - c1);
                slope = (span * 256 + len / 2) / len;
                step  = ((c - k1) * slope + 128) >> 8;
                if (step > span) begin
                    step = span;
                end
                return (c1 >= c2) ? COND_W'(c1 - step) : COND_W'(c1 + step);
            end
        end
        return KNOT_COND[NUM_POINTS - 1];
    endfunction

    // predicts a reading; for a present sample it updates the shadow average as the block does
    function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
        reading_t r;
        logic [CODE_W-1:0] c;
        longint diff;
        longint delta;
        c = code & CODE_MASK;
        r.present = (c > min_shadow) && (c < max_shadow);
        r.raw = '0;
        if (r.present) begin
            r.raw = cal_lookup(c);
            diff  = longint'(r.raw) - longint'(average_shadow);
            delta = (diff * longint'(weight_shadow)) >>> FRAC_W;
            average_shadow = COND_W'(longint'(average_shadow) + delta);
        end
        r.smoothed = average_shadow;
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] gen_code();
        int v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 65 && int'(max_shadow) > int'(min_shadow) + 1) begin
            v = $urandom_range(int'(max_shadow) - 1, int'(min_shadow) + 1);
        end else if (pick < 82) begin
            v = int'(cal_knot($urandom_range(NUM_POINTS - 1))) + int'($urandom_range(6)) - 3;
        end else begin
            v = $urandom_range(CODE_TOP);
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > int'(CODE_TOP)) begin
            v = CODE_TOP;
        end
        return CODE_W'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        end
        mismatch_count++;
    endtask

    task automatic send_sample(input logic [CODE_W-1:0] code);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_adc_code = code;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_readings.push_back(predict_reading(code));
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SMOOTHING_WEIGHT: weight_shadow = data;
            REG_VALID_MIN_CODE:   min_shadow    = data[CODE_W-1:0];
            REG_VALID_MAX_CODE:   max_shadow    = data[CODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int weight, input int lo, input int hi);
        end_burst();
        wait_drained();
        write_reg(REG_SMOOTHING_WEIGHT, WEIGHT_W'(weight));
        write_reg(REG_VALID_MIN_CODE, {6'($urandom), CODE_W'(lo)});
        write_reg(REG_VALID_MAX_CODE, {6'($urandom), CODE_W'(hi)});
    endtask

    task automatic pick_setting();
        int weight;
        int lo;
        int hi;
        case ($urandom_range(4))
            0: weight = 0;
            1: weight = 65535;
            2: weight = WEIGHT_RESET;
            default: weight = $urandom_range(65535);
        endcase
        case ($urandom_range(5))
            0: begin
                lo = VALID_MIN_RST;
                hi = VALID_MAX_RST;
            end
            1: begin
                lo = 0;
                hi = CODE_TOP;
            end
            2: begin
                lo = $urandom_range(CODE_TOP - 1, 1);
                hi = lo + 1 - int'($urandom_range(2));
            end
            default: begin
                lo = $urandom_range(200);
                hi = $urandom_range(CODE_TOP, lo + 2);
            end
        endcase
        apply_setting(weight, lo, hi);
    endtask

    task automatic test_reset_window();
        logic [CODE_W-1:0] codes[7] = '{0, 16, 17, 100, 324, 325, 1023};
        idle_pct  = 0;
        stall_pct = 0;
        foreach (codes[i]) begin
            send_sample(codes[i]);
        end
    endtask

    task automatic test_calibration_knots();
        logic [CODE_W-1:0] codes[14] =
            '{1, 30, 31, 32, 93, 155, 217, 264, 285, 301, 309, 310, 311, 1022};
        apply_setting(65535, 0, CODE_TOP);
        foreach (codes[i]) begin
            send_sample(codes[i]);
        end
    endtask

    task automatic test_edge_settings();
        // zero weight holds the average, then an empty window blocks every sample
        apply_setting(0, 0, CODE_TOP);
        send_sample(100);
        send_sample(500);
        apply_setting(WEIGHT_RESET, 500, 501);
        send_sample(500);
        send_sample(501);
    endtask

    task automatic test_random_traffic();
        int idle_set[4]  = '{0, 59, 0, 14};
        int stall_set[4] = '{0, 0, 59, 14};
        for (int p = 0; p < 4; p++) begin
            for (int chunk = 0; chunk < 4; chunk++) begin
                pick_setting();
                idle_pct  = idle_set[p];
                stall_pct = stall_set[p];
                repeat (105) send_sample(gen_code());
            end
        end
    endtask

    task automatic test_result_holdoff();
        apply_setting(WEIGHT_RESET, VALID_MIN_RST, VALID_MAX_RST);
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge aclk);
        ready_hold = 400;
        repeat (30) send_sample(gen_code());
    endtask

    task automatic test_drain_pause();
        idle_pct  = 14;
        stall_pct = 59;
        repeat (10) send_sample(gen_code());
        end_burst();
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) send_sample(gen_code());
    endtask

    // result side: ready pattern, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_ready    = 1'b0;
                ready_hold = ready_hold - 1;
            end else begin
                m_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // each result transaction is compared with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected result raw", m_raw_conductance, -1);
            end else begin
                oldest_reading = expected_readings.pop_front();
                if (m_sensor_present !== oldest_reading.present) begin
                    report_mismatch("sensor_present", m_sensor_present, oldest_reading.present);
                end
                if (m_raw_conductance !== oldest_reading.raw) begin
                    report_mismatch("raw_conductance", m_raw_conductance, oldest_reading.raw);
                end
                if (m_smoothed_conductance !== oldest_reading.smoothed) begin
                    report_mismatch("smoothed_conductance", m_smoothed_conductance,
                                    oldest_reading.smoothed);
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_adc_code     = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_SMOOTHING_WEIGHT;
        cfg_data       = '0;
        mismatch_count = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        ready_hold     = 0;
        weight_shadow  = WEIGHT_RESET;
        min_shadow     = VALID_MIN_RST;
        max_shadow     = VALID_MAX_RST;
        average_shadow = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_window();
        test_calibration_knots();
        test_edge_settings();
        test_random_traffic();
        test_result_holdoff();
        test_drain_pause();

        end_burst();
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
